/* src/pva_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the polyphonic voice allocator.
// Used by pva_ctrl, pva_datapath and poly_voice_allocator; depends on nothing.
package pva_pkg;

  localparam int NUM_VOICES  = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic       CMD_NOTE_ON  = 1'b0;
  localparam logic       CMD_NOTE_OFF = 1'b1;

  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_START    = 2'd1;
  localparam logic [1:0] ACT_RELEASE  = 2'd2;

  localparam logic [4:0] LISTEN_RESET = 5'd1;

  typedef struct packed {
    logic        command;
    logic [4:0]  event_channel;
    logic [6:0]  note_number;
    logic [15:0] time_delta;
  } pva_in_t;

  typedef struct packed {
    logic [2:0] voice_index;
    logic [1:0] action;
    logic       retrigger;
    logic [6:0] assigned_note;
    logic       last;
  } pva_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic age;
    logic scan_on;
    logic commit_on;
    logic release_v;
    logic skip;
    logic emit_none;
  } pva_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chan_match;
    logic is_off;
    logic idx_last;
    logic out_free;
    logic off_any;
    logic cur_match;
    logic release_last;
  } pva_stat_t;

endpackage

/* src/poly_voice_allocator.sv */
`timescale 1ns / 1ps
// Polyphonic voice allocator, top level. Depends on pva_pkg, pva_ctrl, pva_datapath.
// Other channel: an empty result. Note-on: one voice compared per cycle, then the
// chosen voice is started. Note-off: one voice per cycle, held while a release waits.
// The input stalls until an item is done, so a new item is not taken before then;
// results wait in one output register.
// Synchronous reset clears all gates, notes and ages and sets listen_channel to 1.
module poly_voice_allocator (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pva_pkg::pva_in_t  in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [4:0]        cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pva_pkg::pva_out_t out_data
);
  import pva_pkg::*;

  pva_cmd_t  cmd;
  pva_stat_t stat;

  assign cfg_ready = 1'b1;

  pva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pva_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* src/pva_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the voice allocator.
// Depends on pva_pkg; drives pva_datapath through command and status structs.
module pva_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pva_pkg::pva_stat_t stat,
  output pva_pkg::pva_cmd_t  cmd
);
  import pva_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE,
    S_SCAN_ON,
    S_COMMIT_ON,
    S_SCAN_OFF,
    S_NONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_AGE;
        end
      end
      S_AGE: begin
        cmd.age = 1'b1;
        if (!stat.chan_match) begin
          state_next = S_NONE;
        end else if (stat.is_off) begin
          state_next = S_SCAN_OFF;
        end else begin
          state_next = S_SCAN_ON;
        end
      end
      S_SCAN_ON: begin
        cmd.scan_on = 1'b1;
        if (stat.idx_last) begin
          state_next = S_COMMIT_ON;
        end
      end
      S_COMMIT_ON: begin
        if (stat.out_free) begin
          cmd.commit_on = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN_OFF: begin
        // The mask is only empty here when no voice held the note at all.
        if (!stat.off_any) begin
          state_next = S_NONE;
        end else if (!stat.cur_match) begin
          cmd.skip = 1'b1;
        end else if (stat.out_free) begin
          cmd.release_v = 1'b1;
          if (stat.release_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_NONE: begin
        if (stat.out_free) begin
          cmd.emit_none = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

  property p_load_only_idle;
    @(posedge clk) disable iff (rst) cmd.load |-> !in_stall;
  endproperty
  a_load_only_idle: assert property (p_load_only_idle)
    else $error("item taken while the controller was busy");

  property p_stall_while_busy;
    @(posedge clk) disable iff (rst) cmd.load |=> in_stall;
  endproperty
  a_stall_while_busy: assert property (p_stall_while_busy)
    else $error("input not stalled after an item was taken");

endmodule

/* src/pva_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the voice allocator: voice state, scan registers and the
// output register. Depends on pva_pkg; commanded by pva_ctrl.
module pva_datapath (
  input  logic               clk,
  input  logic               rst,
  input  pva_pkg::pva_in_t   in_data,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  pva_pkg::pva_cmd_t  cmd,
  output pva_pkg::pva_stat_t stat,
  input  logic               out_stall,
  output logic               out_valid,
  output pva_pkg::pva_out_t  out_data
);
  import pva_pkg::*;

  pva_in_t                item;
  logic [4:0]             listen_channel;
  logic [NUM_VOICES-1:0]  voice_gate;
  logic [6:0]             voice_note [NUM_VOICES];
  logic [31:0]            voice_age  [NUM_VOICES];
  logic [NUM_VOICES-1:0]  match_mask;
  logic [NUM_VOICES-1:0]  match_next;
  logic [NUM_VOICES-1:0]  rest_mask;
  logic [IDX_W-1:0]       scan_idx;
  logic [CNT_W-1:0]       release_count;
  logic                   f_found;
  logic [IDX_W-1:0]       f_idx;
  logic [31:0]            f_age;
  logic                   g_found;
  logic [IDX_W-1:0]       g_idx;
  logic [31:0]            g_age;
  logic [IDX_W-1:0]       chosen;
  logic                   cur_gate;
  logic [31:0]            cur_age;
  logic                   out_free;
  logic [32:0]            age_sum [NUM_VOICES];

  assign cur_gate = voice_gate[scan_idx];
  assign cur_age  = voice_age[scan_idx];
  assign chosen   = f_found ? f_idx : g_idx;
  assign out_free = !out_valid || !out_stall;
  assign rest_mask = match_mask & ~(NUM_VOICES'(1) << scan_idx);

  always_comb begin
    for (int v = 0; v < NUM_VOICES; v++) begin
      match_next[v] = voice_gate[v] && (voice_note[v] == item.note_number);
      age_sum[v]    = {1'b0, voice_age[v]} + 33'(item.time_delta);
    end
  end

  always_comb begin
    stat.chan_match   = (item.event_channel == listen_channel);
    stat.is_off       = (item.command == CMD_NOTE_OFF);
    stat.idx_last     = (scan_idx == IDX_W'(NUM_VOICES - 1));
    stat.out_free     = out_free;
    stat.off_any      = |match_mask;
    stat.cur_match    = match_mask[scan_idx];
    stat.release_last = (rest_mask == '0) ||
                        (release_count == CNT_W'(MAX_RESULTS - 1));
  end

  // Item and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel <= LISTEN_RESET;
    end else if (cfg_we) begin
      listen_channel <= cfg_data;
    end
    if (cmd.load) begin
      item <= in_data;
    end
  end

  // Voice state.
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_gate <= '0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        voice_note[v] <= '0;
        voice_age[v]  <= '0;
      end
    end else begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        if (cmd.age) begin
          voice_age[v] <= age_sum[v][32] ? '1 : age_sum[v][31:0];
        end else if (cmd.commit_on && chosen == IDX_W'(v)) begin
          voice_age[v] <= '0;
        end
      end
      if (cmd.commit_on) begin
        voice_gate[chosen] <= 1'b1;
        voice_note[chosen] <= item.note_number;
      end
      if (cmd.release_v) begin
        voice_gate[scan_idx] <= 1'b0;
      end
    end
  end

  // Scan registers: one voice looked at per cycle, except while a release waits for the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx      <= '0;
      release_count <= '0;
      match_mask    <= '0;
      f_found       <= 1'b0;
      g_found       <= 1'b0;
    end else if (cmd.age) begin
      scan_idx      <= '0;
      release_count <= '0;
      match_mask    <= match_next;
      f_found       <= 1'b0;
      g_found       <= 1'b0;
    end else begin
      if (cmd.scan_on) begin
        // Strictly older replaces, so ties stay with the lower index.
        if (cur_gate) begin
          if (!g_found || cur_age > g_age) begin
            g_found <= 1'b1;
            g_idx   <= scan_idx;
            g_age   <= cur_age;
          end
        end else begin
          if (!f_found || cur_age > f_age) begin
            f_found <= 1'b1;
            f_idx   <= scan_idx;
            f_age   <= cur_age;
          end
        end
      end
      if (cmd.scan_on || cmd.skip || cmd.release_v) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmd.release_v) begin
        match_mask[scan_idx] <= 1'b0;
        release_count        <= release_count + CNT_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit_on || cmd.release_v || cmd.emit_none) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.commit_on) begin
      out_data.voice_index   <= 3'(chosen);
      out_data.action        <= ACT_START;
      out_data.retrigger     <= !f_found;
      out_data.assigned_note <= item.note_number;
      out_data.last          <= 1'b1;
    end else if (cmd.release_v) begin
      out_data.voice_index   <= 3'(scan_idx);
      out_data.action        <= ACT_RELEASE;
      out_data.retrigger     <= 1'b0;
      out_data.assigned_note <= item.note_number;
      out_data.last          <= stat.release_last;
    end else if (cmd.emit_none) begin
      out_data <= '{voice_index: 3'd0, action: ACT_NONE, retrigger: 1'b0,
                    assigned_note: 7'd0, last: 1'b1};
    end
  end

  property p_no_overwrite;
    @(posedge clk) disable iff (rst)
      (out_valid && out_stall) |-> !(cmd.commit_on || cmd.release_v || cmd.emit_none);
  endproperty
  a_no_overwrite: assert property (p_no_overwrite)
    else $error("result written over an item not yet taken");

  property p_commit_gates;
    @(posedge clk) disable iff (rst)
      cmd.commit_on |=> voice_gate[$past(chosen)] && (voice_age[$past(chosen)] == '0);
  endproperty
  a_commit_gates: assert property (p_commit_gates)
    else $error("started voice not gated with cleared age");

  property p_release_clears;
    @(posedge clk) disable iff (rst)
      cmd.release_v |=> !voice_gate[$past(scan_idx)];
  endproperty
  a_release_clears: assert property (p_release_clears)
    else $error("released voice still gated");

  property p_none_fields;
    @(posedge clk) disable iff (rst)
      (out_valid && out_data.action == ACT_NONE) |->
        (out_data.voice_index == 3'd0 && out_data.assigned_note == 7'd0 &&
         out_data.last && !out_data.retrigger);
  endproperty
  a_none_fields: assert property (p_none_fields)
    else $error("empty result carries non-zero fields");

endmodule
